/* rtl/edc_pkg.sv */
// edc_pkg: constants, shared types and the month offset table for the civil date pipeline
package edc_pkg;

	// seconds split
	localparam logic [31:0] DAY_SECONDS    = 32'd86400;
	localparam logic [31:0] DAY_RECIP      = 32'd3257812230; // floor(2^48 / 86400)
	localparam logic [16:0] HOUR_SECONDS   = 17'd3600;
	localparam logic [5:0]  HOUR_RECIP     = 6'd36;          // floor(2^17 / 3600)
	localparam logic [11:0] MINUTE_SECONDS = 12'd60;
	localparam logic [6:0]  MINUTE_RECIP   = 7'd68;          // floor(2^12 / 60)

	// weekday, 1970-01-01 was a thursday
	localparam logic [15:0] THURSDAY       = 16'd4;
	localparam logic [13:0] WEEK_RECIP     = 14'd9362;       // floor(2^16 / 7)
	localparam logic [15:0] WEEK_DAYS      = 16'd7;

	// day count to march-based eras
	localparam logic [19:0] MARCH0_TO_1970 = 20'd719468;
	localparam logic [19:0] ERA4_START     = 20'd584388;     // 4 * 146097
	localparam logic [19:0] ERA5_START     = 20'd730485;     // 5 * 146097

	localparam logic [17:0] LEAP4_DAYS     = 18'd1460;
	localparam logic [7:0]  LEAP4_RECIP    = 8'd179;         // floor(2^18 / 1460)
	localparam logic [17:0] CENT_DAYS      = 18'd36524;
	localparam logic [17:0] ERA_LAST_DAY   = 18'd146096;
	localparam logic [17:0] YEAR_DAYS      = 18'd365;
	localparam logic [9:0]  YEAR_RECIP     = 10'd718;        // floor(2^18 / 365)

	localparam logic [10:0] MONTH_SPAN     = 11'd153;
	localparam logic [3:0]  MONTH_RECIP    = 4'd13;          // floor(2^11 / 153)
	localparam logic [3:0]  MARCH_TO_JAN   = 4'd10;

	// year minus 1900 modulo 256, era 4 starts at 1600, era 5 at 2000
	localparam logic [7:0]  YEAR_BASE4     = 8'd212;
	localparam logic [7:0]  YEAR_BASE5     = 8'd100;

	typedef struct packed {
		logic [5:0] sec;
		logic [5:0] min;
		logic [4:0] hr;
		logic [2:0] wd;
	} tod_t;

	typedef struct packed {
		logic [17:0] ic;     // day within the 400-year era
		logic [17:0] numer;  // era day with leap days taken out
		logic        cyc5;   // era starting in 2000
	} date_mid_t;

	typedef struct packed {
		tod_t       tod;
		logic [4:0] mday;
		logic [3:0] mon;
		logic [7:0] year;
	} civil_t;

	// first day of each march-based month within its year
	function automatic logic [8:0] month_start(input logic [3:0] mm);
		logic [8:0] d;
		case (mm)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd61;
			4'd3:    d = 9'd92;
			4'd4:    d = 9'd122;
			4'd5:    d = 9'd153;
			4'd6:    d = 9'd184;
			4'd7:    d = 9'd214;
			4'd8:    d = 9'd245;
			4'd9:    d = 9'd275;
			4'd10:   d = 9'd306;
			4'd11:   d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/edc_split.sv */
// edc_split: three stage split of the seconds count into day count and second of day
module edc_split import edc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] secs,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] days,
	output logic [16:0] rem
);

	logic        valid_s1, valid_s2, valid_s3;
	logic        take1, take2, take3;
	logic [31:0] t_s1;
	logic [15:0] q0_s1, q0_s2;
	logic [17:0] r0_s2;
	logic [15:0] days_s3;
	logic [16:0] rem_s3;

	logic [63:0] prod;
	logic [31:0] r0_full;

	assign take3    = !valid_s3 || out_ready;
	assign take2    = !valid_s2 || take3;
	assign take1    = !valid_s1 || take2;
	assign in_ready = take1;

	// estimate may be one short, fixed in the last stage
	assign prod    = 64'(secs) * 64'(DAY_RECIP);
	assign r0_full = t_s1 - 32'(q0_s1) * DAY_SECONDS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (take1) valid_s1 <= in_valid;
			if (take2) valid_s2 <= valid_s1;
			if (take3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take1 && in_valid) begin
			t_s1  <= secs;
			q0_s1 <= prod[63:48];
		end
		if (take2 && valid_s1) begin
			q0_s2 <= q0_s1;
			r0_s2 <= r0_full[17:0];
		end
		if (take3 && valid_s2) begin
			if (r0_s2 >= DAY_SECONDS[17:0]) begin
				days_s3 <= q0_s2 + 16'd1;
				rem_s3  <= 17'(r0_s2 - DAY_SECONDS[17:0]);
			end else begin
				days_s3 <= q0_s2;
				rem_s3  <= r0_s2[16:0];
			end
		end
	end

	assign out_valid = valid_s3;
	assign days      = days_s3;
	assign rem       = rem_s3;

endmodule

/* rtl/edc_front.sv */
// edc_front: time of day, weekday and era day count, four pipeline stages
module edc_front import edc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] days,
	input  logic [16:0] rem,
	output logic        out_valid,
	input  logic        out_ready,
	output tod_t        tod,
	output date_mid_t   mid
);

	logic valid_s4, valid_s5, valid_s6, valid_s7;
	logic take4, take5, take6, take7;

	// stage 4
	logic [16:0] rem_s4;
	logic [4:0]  hq0_s4;
	logic [15:0] wdx_s4;
	logic [12:0] wq0_s4;
	logic [17:0] ic_s4;
	logic        cyc5_s4;
	// stage 5
	logic [4:0]  hr_s5;
	logic [11:0] rem2_s5;
	logic [2:0]  wd_s5;
	logic [17:0] ic_s5;
	logic [6:0]  iq0_s5;
	logic [2:0]  ccent_s5;
	logic        clast_s5;
	logic        cyc5_s5;
	// stage 6
	logic [4:0]  hr_s6;
	logic [11:0] rem2_s6;
	logic [5:0]  mq0_s6;
	logic [2:0]  wd_s6;
	logic [17:0] ic_s6;
	logic [6:0]  q1460_s6;
	logic [2:0]  ccent_s6;
	logic        clast_s6;
	logic        cyc5_s6;
	// stage 7
	tod_t        tod_s7;
	date_mid_t   mid_s7;

	logic [19:0] shifted;
	logic        cyc5;
	logic [22:0] hr_prod;
	logic [15:0] wdx;
	logic [29:0] wd_prod;
	logic [16:0] hr_r;
	logic [15:0] wd_r;
	logic [25:0] iq_prod;
	logic [17:0] iq_r;
	logic [17:0] mn_prod;
	logic [11:0] mn_r;

	assign take7    = !valid_s7 || out_ready;
	assign take6    = !valid_s6 || take7;
	assign take5    = !valid_s5 || take6;
	assign take4    = !valid_s4 || take5;
	assign in_ready = take4;

	// stage 4 logic
	assign shifted = 20'(days) + MARCH0_TO_1970;
	assign cyc5    = shifted >= ERA5_START;
	assign hr_prod = 23'(rem) * 23'(HOUR_RECIP);
	assign wdx     = days + THURSDAY;
	assign wd_prod = 30'(wdx) * 30'(WEEK_RECIP);

	// stage 5 logic
	assign hr_r    = rem_s4 - 17'(hq0_s4) * HOUR_SECONDS;
	assign wd_r    = wdx_s4 - 16'(wq0_s4) * WEEK_DAYS;
	assign iq_prod = 26'(ic_s4) * 26'(LEAP4_RECIP);

	// stage 6 logic
	assign iq_r    = ic_s5 - 18'(iq0_s5) * LEAP4_DAYS;
	assign mn_prod = 18'(rem2_s5) * 18'(MINUTE_RECIP);

	// stage 7 logic
	assign mn_r    = rem2_s6 - 12'(mq0_s6) * MINUTE_SECONDS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (take4) valid_s4 <= in_valid;
			if (take5) valid_s5 <= valid_s4;
			if (take6) valid_s6 <= valid_s5;
			if (take7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (take4 && in_valid) begin
			rem_s4  <= rem;
			hq0_s4  <= hr_prod[21:17];
			wdx_s4  <= wdx;
			wq0_s4  <= wd_prod[28:16];
			cyc5_s4 <= cyc5;
			ic_s4   <= 18'(shifted - (cyc5 ? ERA5_START : ERA4_START));
		end
		if (take5 && valid_s4) begin
			if (hr_r >= HOUR_SECONDS) begin
				hr_s5   <= hq0_s4 + 5'd1;
				rem2_s5 <= 12'(hr_r - HOUR_SECONDS);
			end else begin
				hr_s5   <= hq0_s4;
				rem2_s5 <= hr_r[11:0];
			end
			wd_s5    <= (wd_r >= WEEK_DAYS) ? 3'(wd_r - WEEK_DAYS) : wd_r[2:0];
			ic_s5    <= ic_s4;
			iq0_s5   <= iq_prod[24:18];
			// whole centuries and the last day of the era
			ccent_s5 <= 3'(ic_s4 >= CENT_DAYS) + 3'(ic_s4 >= 18'(2 * CENT_DAYS))
				+ 3'(ic_s4 >= 18'(3 * CENT_DAYS)) + 3'(ic_s4 >= ERA_LAST_DAY);
			clast_s5 <= ic_s4 >= ERA_LAST_DAY;
			cyc5_s5  <= cyc5_s4;
		end
		if (take6 && valid_s5) begin
			hr_s6    <= hr_s5;
			rem2_s6  <= rem2_s5;
			mq0_s6   <= mn_prod[17:12];
			wd_s6    <= wd_s5;
			ic_s6    <= ic_s5;
			q1460_s6 <= (iq_r >= LEAP4_DAYS) ? iq0_s5 + 7'd1 : iq0_s5;
			ccent_s6 <= ccent_s5;
			clast_s6 <= clast_s5;
			cyc5_s6  <= cyc5_s5;
		end
		if (take7 && valid_s6) begin
			tod_s7.hr <= hr_s6;
			tod_s7.wd <= wd_s6;
			if (mn_r >= MINUTE_SECONDS) begin
				tod_s7.min <= mq0_s6 + 6'd1;
				tod_s7.sec <= 6'(mn_r - MINUTE_SECONDS);
			end else begin
				tod_s7.min <= mq0_s6;
				tod_s7.sec <= mn_r[5:0];
			end
			mid_s7.ic    <= ic_s6;
			mid_s7.numer <= ic_s6 - 18'(q1460_s6) + 18'(ccent_s6) - 18'(clast_s6);
			mid_s7.cyc5  <= cyc5_s6;
		end
	end

	assign out_valid = valid_s7;
	assign tod       = tod_s7;
	assign mid       = mid_s7;

endmodule

/* rtl/edc_back.sv */
// edc_back: year, month and day of month from the era day count, seven pipeline stages
module edc_back import edc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  tod_t      tod,
	input  date_mid_t mid,
	output logic      out_valid,
	input  logic      out_ready,
	output civil_t    civil
);

	logic valid_s8, valid_s9, valid_s10, valid_s11, valid_s12, valid_s13, valid_s14;
	logic take8, take9, take10, take11, take12, take13, take14;

	tod_t        tod_s8, tod_s9, tod_s10, tod_s11, tod_s12, tod_s13;
	logic [17:0] ic_s8, ic_s9, ic_s10;
	logic        cyc5_s8, cyc5_s9;
	logic [17:0] numer_s8;
	logic [8:0]  yq0_s8;
	logic [8:0]  y_s9;
	logic [17:0] yoff_s10;
	logic [7:0]  ybase_s10, ybase_s11, ybase_s12, ybase_s13;
	logic [8:0]  iny_s11, iny_s12, iny_s13;
	logic [10:0] mnum_s12;
	logic [3:0]  mq0_s12;
	logic [3:0]  mm_s13;
	civil_t      civil_s14;

	logic [27:0] y_prod;
	logic [17:0] y_r;
	logic [1:0]  cent;
	logic [17:0] iny_full;
	logic [10:0] mnum;
	logic [14:0] m_prod;
	logic [10:0] m_r;
	logic        jan_feb;

	assign take14   = !valid_s14 || out_ready;
	assign take13   = !valid_s13 || take14;
	assign take12   = !valid_s12 || take13;
	assign take11   = !valid_s11 || take12;
	assign take10   = !valid_s10 || take11;
	assign take9    = !valid_s9 || take10;
	assign take8    = !valid_s8 || take9;
	assign in_ready = take8;

	assign y_prod   = 28'(mid.numer) * 28'(YEAR_RECIP);
	assign y_r      = numer_s8 - 18'(yq0_s8) * YEAR_DAYS;
	assign cent     = 2'(y_s9 >= 9'd100) + 2'(y_s9 >= 9'd200) + 2'(y_s9 >= 9'd300);
	assign iny_full = ic_s10 - yoff_s10;
	assign mnum     = 11'(iny_s11) * 11'd5 + 11'd2;
	assign m_prod   = 15'(mnum) * 15'(MONTH_RECIP);
	assign m_r      = mnum_s12 - 11'(mq0_s12) * MONTH_SPAN;
	// january and february belong to the next calendar year
	assign jan_feb  = mm_s13 >= MARCH_TO_JAN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8  <= 1'b0;
			valid_s9  <= 1'b0;
			valid_s10 <= 1'b0;
			valid_s11 <= 1'b0;
			valid_s12 <= 1'b0;
			valid_s13 <= 1'b0;
			valid_s14 <= 1'b0;
		end else begin
			if (take8)  valid_s8  <= in_valid;
			if (take9)  valid_s9  <= valid_s8;
			if (take10) valid_s10 <= valid_s9;
			if (take11) valid_s11 <= valid_s10;
			if (take12) valid_s12 <= valid_s11;
			if (take13) valid_s13 <= valid_s12;
			if (take14) valid_s14 <= valid_s13;
		end
	end

	always_ff @(posedge clk) begin
		if (take8 && in_valid) begin
			tod_s8   <= tod;
			ic_s8    <= mid.ic;
			cyc5_s8  <= mid.cyc5;
			numer_s8 <= mid.numer;
			yq0_s8   <= y_prod[26:18];
		end
		if (take9 && valid_s8) begin
			tod_s9  <= tod_s8;
			ic_s9   <= ic_s8;
			cyc5_s9 <= cyc5_s8;
			y_s9    <= (y_r >= YEAR_DAYS) ? yq0_s8 + 9'd1 : yq0_s8;
		end
		if (take10 && valid_s9) begin
			tod_s10   <= tod_s9;
			ic_s10    <= ic_s9;
			yoff_s10  <= 18'(y_s9) * YEAR_DAYS + 18'(y_s9[8:2]) - 18'(cent);
			ybase_s10 <= y_s9[7:0] + (cyc5_s9 ? YEAR_BASE5 : YEAR_BASE4);
		end
		if (take11 && valid_s10) begin
			tod_s11   <= tod_s10;
			ybase_s11 <= ybase_s10;
			iny_s11   <= iny_full[8:0];
		end
		if (take12 && valid_s11) begin
			tod_s12   <= tod_s11;
			ybase_s12 <= ybase_s11;
			iny_s12   <= iny_s11;
			mnum_s12  <= mnum;
			mq0_s12   <= m_prod[14:11];
		end
		if (take13 && valid_s12) begin
			tod_s13   <= tod_s12;
			ybase_s13 <= ybase_s12;
			iny_s13   <= iny_s12;
			mm_s13    <= (m_r >= MONTH_SPAN) ? mq0_s12 + 4'd1 : mq0_s12;
		end
		if (take14 && valid_s13) begin
			civil_s14.tod  <= tod_s13;
			civil_s14.mday <= 5'(iny_s13 - month_start(mm_s13) + 9'd1);
			civil_s14.mon  <= jan_feb ? mm_s13 - MARCH_TO_JAN : mm_s13 + 4'd2;
			civil_s14.year <= ybase_s13 + 8'(jan_feb);
		end
	end

	assign out_valid = valid_s14;
	assign civil     = civil_s14;

endmodule

/* rtl/epoch_seconds_to_civil_date.sv */
// 14 pipeline stages: edc_split s1 to s3, edc_front s4 to s7, edc_back s8 to s14
// one item per cycle while civil_stall is low, since every stage then hands its item on
// each stage holds only while its successor is full and stalled, so bubbles close up
// reset clears the stage valid bits at once; the data registers are not reset
// epoch_seconds_to_civil_date: top level, unix seconds to broken-down civil time
module epoch_seconds_to_civil_date import edc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        epoch_valid,
	output logic        epoch_stall,
	input  logic [31:0] epoch_seconds,
	output logic        civil_valid,
	input  logic        civil_stall,
	output logic [5:0]  second_of_minute,
	output logic [5:0]  minute_of_hour,
	output logic [4:0]  hour_of_day,
	output logic [2:0]  weekday,
	output logic [4:0]  day_of_month,
	output logic [3:0]  month_index,
	output logic [7:0]  year_since_1900
);

	logic        split_ready, split_valid;
	logic [15:0] days;
	logic [16:0] rem;
	logic        front_ready, front_valid;
	tod_t        tod;
	date_mid_t   mid;
	logic        back_ready;
	civil_t      civil;

	edc_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (epoch_valid),
		.in_ready  (split_ready),
		.secs      (epoch_seconds),
		.out_valid (split_valid),
		.out_ready (front_ready),
		.days      (days),
		.rem       (rem)
	);

	edc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (split_valid),
		.in_ready  (front_ready),
		.days      (days),
		.rem       (rem),
		.out_valid (front_valid),
		.out_ready (back_ready),
		.tod       (tod),
		.mid       (mid)
	);

	edc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (back_ready),
		.tod       (tod),
		.mid       (mid),
		.out_valid (civil_valid),
		.out_ready (!civil_stall),
		.civil     (civil)
	);

	assign epoch_stall      = !split_ready;
	assign second_of_minute = civil.tod.sec;
	assign minute_of_hour   = civil.tod.min;
	assign hour_of_day      = civil.tod.hr;
	assign weekday          = civil.tod.wd;
	assign day_of_month     = civil.mday;
	assign month_index      = civil.mon;
	assign year_since_1900  = civil.year;

endmodule

/* dv/civil_date_checker.sv */
// civil_date_checker: predicts and checks each civil item of the epoch to date converter
`timescale 1ns / 100ps

module civil_date_checker import edc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        epoch_valid,
	input  logic        epoch_stall,
	input  logic [31:0] epoch_seconds,
	input  logic        civil_valid,
	input  logic        civil_stall,
	input  logic [5:0]  second_of_minute,
	input  logic [5:0]  minute_of_hour,
	input  logic [4:0]  hour_of_day,
	input  logic [2:0]  weekday,
	input  logic [4:0]  day_of_month,
	input  logic [3:0]  month_index,
	input  logic [7:0]  year_since_1900,
	output int          fail_count,
	output int          pending_count,
	output int          checked_count
);

	localparam int unsigned DAY_SECS       = 86400;
	localparam int unsigned HOUR_SECS      = 3600;
	localparam int unsigned MINUTE_SECS    = 60;
	localparam int unsigned ERA_DAYS       = 146097;
	localparam int unsigned DAYS_TO_1970   = 719468;
	localparam int unsigned EPOCH_WEEKDAY  = 4;
	localparam int unsigned YEAR_OFFSET    = 1900;

	civil_t expected_dates[$];

	// days are counted from 0000-03-01 so the leap day falls at the end of each year
	function automatic civil_t civil_of_epoch(input logic [31:0] secs);
		int unsigned days, rem, hr, mn, shifted, era, doe, yoe, doy, mp, yr, mon;
		civil_t c;
		days = secs / DAY_SECS;
		rem = secs - days * DAY_SECS;
		hr = rem / HOUR_SECS;
		rem -= hr * HOUR_SECS;
		mn = rem / MINUTE_SECS;
		c.tod.sec = 6'(rem - mn * MINUTE_SECS);
		c.tod.min = 6'(mn);
		c.tod.hr = 5'(hr);
		c.tod.wd = 3'((days + EPOCH_WEEKDAY) % 7);
		shifted = days + DAYS_TO_1970;
		era = shifted / ERA_DAYS;
		doe = shifted - era * ERA_DAYS;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		yr = yoe + era * 400;
		c.mday = 5'(doy - (153 * mp + 2) / 5 + 1);
		if (mp < 10) begin
			mon = mp + 2;
		end else begin
			mon = mp - 10;
			yr += 1;
		end
		c.mon = 4'(mon);
		c.year = 8'(yr - YEAR_OFFSET);
		return c;
	endfunction

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("civil item field %s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		civil_t want;
		if (!arst_n) begin
			fail_count = 0;
			checked_count = 0;
			expected_dates.delete();
		end else begin
			if (civil_valid && !civil_stall) begin
				if (expected_dates.size() == 0) begin
					$error("civil item with no timestamp outstanding");
					fail_count++;
				end else begin
					want = expected_dates.pop_front();
					compare_field("second_of_minute", want.tod.sec, second_of_minute);
					compare_field("minute_of_hour", want.tod.min, minute_of_hour);
					compare_field("hour_of_day", want.tod.hr, hour_of_day);
					compare_field("weekday", want.tod.wd, weekday);
					compare_field("day_of_month", want.mday, day_of_month);
					compare_field("month_index", want.mon, month_index);
					compare_field("year_since_1900", want.year, year_since_1900);
					checked_count++;
				end
			end
			if (epoch_valid && !epoch_stall)
				expected_dates.push_back(civil_of_epoch(epoch_seconds));
		end
		pending_count <= expected_dates.size();
	end

endmodule

/* dv/tb_top.sv */
// tb_top: stimulus, handshake idling and verdict for the epoch to civil date converter
`timescale 1ns / 100ps

module tb_top;

	localparam int DRAIN_CYCLES = 30;
	localparam int RANDOM_ITEMS = 550;
	localparam int LAST_FULL_DAY = 49709;

	logic        clk;
	logic        arst_n;
	logic        epoch_valid;
	logic        epoch_stall;
	logic [31:0] epoch_seconds;
	logic        civil_valid;
	logic        civil_stall = 1'b0;
	logic [5:0]  second_of_minute;
	logic [5:0]  minute_of_hour;
	logic [4:0]  hour_of_day;
	logic [2:0]  weekday;
	logic [4:0]  day_of_month;
	logic [3:0]  month_index;
	logic [7:0]  year_since_1900;

	int fail_count;
	int pending_count;
	int checked_count;
	int sent_count;
	int stall_left;
	bit steady;

	epoch_seconds_to_civil_date dut (
		.clk(clk), .arst_n(arst_n),
		.epoch_valid(epoch_valid), .epoch_stall(epoch_stall), .epoch_seconds(epoch_seconds),
		.civil_valid(civil_valid), .civil_stall(civil_stall),
		.second_of_minute(second_of_minute), .minute_of_hour(minute_of_hour),
		.hour_of_day(hour_of_day), .weekday(weekday), .day_of_month(day_of_month),
		.month_index(month_index), .year_since_1900(year_since_1900)
	);

	civil_date_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.epoch_valid(epoch_valid), .epoch_stall(epoch_stall), .epoch_seconds(epoch_seconds),
		.civil_valid(civil_valid), .civil_stall(civil_stall),
		.second_of_minute(second_of_minute), .minute_of_hour(minute_of_hour),
		.hour_of_day(hour_of_day), .weekday(weekday), .day_of_month(day_of_month),
		.month_index(month_index), .year_since_1900(year_since_1900),
		.fail_count(fail_count), .pending_count(pending_count),
		.checked_count(checked_count)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// output back-pressure: none while steady, else runs of free cycles, short stalls and now and then a long one
	always @(posedge clk) begin
		int r;
		if (steady) begin
			civil_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				civil_stall <= 1'b0;
				stall_left = $urandom_range(0, 6);
			end else if (r < 92) begin
				civil_stall <= 1'b1;
				stall_left = $urandom_range(0, 2);
			end else begin
				civil_stall <= 1'b1;
				stall_left = $urandom_range(8, 40);
			end
		end
	end

	task automatic send_epoch(input logic [31:0] secs);
		int gap;
		epoch_valid <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (epoch_stall);
		sent_count++;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			epoch_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] random_epoch();
		logic [31:0] days;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: begin
				// mostly around midnight, where date and weekday roll over
				days = $urandom_range(0, LAST_FULL_DAY);
				case ($urandom_range(0, 3))
					0: return days * 86400;
					1: return days * 86400 + 1;
					2: return days * 86400 + 86399;
					default: return days * 86400 + $urandom_range(0, 86399);
				endcase
			end
			7: begin
				days = $urandom_range(0, LAST_FULL_DAY);
				return days * 86400 + $urandom_range(0, 23) * 3600
					+ (($urandom_range(0, 1) == 1) ? 3599 : 59);
			end
			8: return $urandom_range(0, 100000000);
			default: return 32'hFFFF_FFFF - $urandom_range(0, 50000000);
		endcase
	endfunction

	initial begin
		logic [31:0] edge_cases[$];
		arst_n = 1'b0;
		epoch_valid = 1'b0;
		epoch_seconds = '0;
		sent_count = 0;
		steady = 1'b0;
		// epoch start, minute/hour/day rollovers, leap days, century years, 2038 and the end
		edge_cases = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
			32'd86400, 32'd68169600, 32'd946684799, 32'd946684800, 32'd951782400,
			32'd951868800, 32'd1078012800, 32'd2147483647, 32'd2147483648,
			32'd4107456000, 32'd4107542400, 32'd4102444799, 32'd4102444800,
			32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (edge_cases[i])
			send_epoch(edge_cases[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 200 && i < 300);
			send_epoch(random_epoch());
		end
		steady = 1'b0;
		epoch_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d timestamps, %0d civil items compared field by field",
			sent_count, checked_count);
		$display("edges: epoch start, leap days, 2000 and 2100, 2038 rollover, last second");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d civil items outstanding", pending_count);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* epoch_seconds_to_civil_date.f */
rtl/edc_pkg.sv
rtl/edc_split.sv
rtl/edc_front.sv
rtl/edc_back.sv
rtl/epoch_seconds_to_civil_date.sv
dv/civil_date_checker.sv
dv/tb_top.sv
